>>> hw/rtl/aic_pkg.sv
// ----------------------------------------------------------------------------
// aic_pkg
// Shared types and codes for the ARM instruction classifier.
// ----------------------------------------------------------------------------
package aic_pkg;

   localparam int unsigned INSTR_W   = 32;
   localparam int unsigned FMT_W     = 4;
   localparam int unsigned COND_W    = 4;
   localparam int unsigned REQ_DATA_W = 40;  // 32 + 4 flag bits, padded to bytes
   localparam int unsigned RSP_DATA_W = 8;   // 4 + 1, padded to bytes

   // format codes
   localparam logic [FMT_W-1:0] FMT_BX      = 4'd0;
   localparam logic [FMT_W-1:0] FMT_BRANCH  = 4'd1;
   localparam logic [FMT_W-1:0] FMT_DP      = 4'd2;
   localparam logic [FMT_W-1:0] FMT_MUL     = 4'd3;
   localparam logic [FMT_W-1:0] FMT_MULL    = 4'd4;
   localparam logic [FMT_W-1:0] FMT_SDT     = 4'd5;
   localparam logic [FMT_W-1:0] FMT_HDT_IMM = 4'd6;
   localparam logic [FMT_W-1:0] FMT_HDT_REG = 4'd7;
   localparam logic [FMT_W-1:0] FMT_BDT     = 4'd8;
   localparam logic [FMT_W-1:0] FMT_SWAP    = 4'd9;
   localparam logic [FMT_W-1:0] FMT_SWI     = 4'd10;
   localparam logic [FMT_W-1:0] FMT_CDO     = 4'd11;
   localparam logic [FMT_W-1:0] FMT_CDT     = 4'd12;
   localparam logic [FMT_W-1:0] FMT_CRT     = 4'd13;
   localparam logic [FMT_W-1:0] FMT_UNDEF   = 4'd14;
   localparam logic [FMT_W-1:0] FMT_UNKNOWN = 4'd15;

   // condition field codes
   localparam logic [COND_W-1:0] COND_EQ = 4'd0;
   localparam logic [COND_W-1:0] COND_NE = 4'd1;
   localparam logic [COND_W-1:0] COND_CS = 4'd2;
   localparam logic [COND_W-1:0] COND_CC = 4'd3;
   localparam logic [COND_W-1:0] COND_MI = 4'd4;
   localparam logic [COND_W-1:0] COND_PL = 4'd5;
   localparam logic [COND_W-1:0] COND_VS = 4'd6;
   localparam logic [COND_W-1:0] COND_VC = 4'd7;
   localparam logic [COND_W-1:0] COND_HI = 4'd8;
   localparam logic [COND_W-1:0] COND_LS = 4'd9;
   localparam logic [COND_W-1:0] COND_GE = 4'd10;
   localparam logic [COND_W-1:0] COND_LT = 4'd11;
   localparam logic [COND_W-1:0] COND_GT = 4'd12;
   localparam logic [COND_W-1:0] COND_LE = 4'd13;
   localparam logic [COND_W-1:0] COND_AL = 4'd14;

   typedef struct packed {
      logic overflow;
      logic carry;
      logic zero;
      logic negative;
   } flags_type;

   typedef struct packed {
      logic             cond_passed;
      logic [FMT_W-1:0] format_code;
   } result_type;

endpackage

>>> hw/rtl/aic_format.sv
// ----------------------------------------------------------------------------
// aic_format
// Priority match of an ARM v4T instruction word onto a dense format code.
// ----------------------------------------------------------------------------
module aic_format
   import aic_pkg::*;
(
   input  logic [INSTR_W-1:0] instr_word,
   output logic [FMT_W-1:0]   format_code
);

   logic [2:0] top3;
   logic [3:0] top4;
   logic       b4;

   assign top3 = instr_word[27:25];
   assign top4 = instr_word[27:24];
   assign b4   = instr_word[4];

   // narrow patterns first, so the broad data processing class cannot hide them
   always_comb begin
      if (instr_word[27:4] == 24'h12FFF1) begin
         format_code = FMT_BX;
      end else if (instr_word[7:4] == 4'b1001 && instr_word[27:22] == 6'b000000) begin
         format_code = FMT_MUL;
      end else if (instr_word[7:4] == 4'b1001 && instr_word[27:23] == 5'b00001) begin
         format_code = FMT_MULL;
      end else if (instr_word[11:4] == 8'b00001001 && instr_word[21:20] == 2'b00 &&
                   instr_word[27:23] == 5'b00010) begin
         format_code = FMT_SWAP;
      end else if (b4 && instr_word[7] && instr_word[22] && top3 == 3'b000) begin
         format_code = FMT_HDT_IMM;
      end else if (b4 && instr_word[11:7] == 5'b00001 && !instr_word[22] &&
                   top3 == 3'b000) begin
         format_code = FMT_HDT_REG;
      end else if (top3 == 3'b101) begin
         format_code = FMT_BRANCH;
      end else if (instr_word[27:26] == 2'b00) begin
         format_code = FMT_DP;
      end else if (top3 == 3'b011 && b4) begin
         format_code = FMT_UNDEF;
      end else if (instr_word[27:26] == 2'b01) begin
         format_code = FMT_SDT;
      end else if (top3 == 3'b100) begin
         format_code = FMT_BDT;
      end else if (top4 == 4'b1111) begin
         format_code = FMT_SWI;
      end else if (!b4 && top4 == 4'b1110) begin
         format_code = FMT_CDO;
      end else if (top3 == 3'b110) begin
         format_code = FMT_CDT;
      end else if (b4 && top4 == 4'b1110) begin
         format_code = FMT_CRT;
      end else begin
         format_code = FMT_UNKNOWN;
      end
   end

endmodule

>>> hw/rtl/aic_cond.sv
// ----------------------------------------------------------------------------
// aic_cond
// Evaluates the condition field against the N, Z, C, V flags.
// ----------------------------------------------------------------------------
module aic_cond
   import aic_pkg::*;
(
   input  logic [COND_W-1:0] cond,
   input  flags_type         flags,
   output logic              cond_passed
);

   logic n_eq_v;

   assign n_eq_v = (flags.negative == flags.overflow);

   always_comb begin
      case (cond)
         COND_EQ: cond_passed = flags.zero;
         COND_NE: cond_passed = !flags.zero;
         COND_CS: cond_passed = flags.carry;
         COND_CC: cond_passed = !flags.carry;
         COND_MI: cond_passed = flags.negative;
         COND_PL: cond_passed = !flags.negative;
         COND_VS: cond_passed = flags.overflow;
         COND_VC: cond_passed = !flags.overflow;
         COND_HI: cond_passed = flags.carry && !flags.zero;
         COND_LS: cond_passed = !flags.carry || flags.zero;
         COND_GE: cond_passed = n_eq_v;
         COND_LT: cond_passed = !n_eq_v;
         COND_GT: cond_passed = !flags.zero && n_eq_v;
         COND_LE: cond_passed = flags.zero || !n_eq_v;
         COND_AL: cond_passed = 1'b1;
         default: cond_passed = 1'b0;  // NV never passes
      endcase
   end

endmodule

>>> hw/rtl/arm_instruction_classify.sv
// ----------------------------------------------------------------------------
// arm_instruction_classify
// Classifies ARM v4T instruction words by format and evaluates their
// condition field against the supplied flags.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  req     | in  | req_tvalid/tready | instr_word, N, Z, C, V
//  rsp     | out | rsp_tvalid/tready | format_code, cond_passed
//
//  One transfer per cycle in each direction while rsp is not stalled;
//  each item passes the input register, then the result register.
//  The decode sits between the two registers and is a single pass.
//  Reset clears both stage valids; no payload is reset.
//  A stall on rsp holds the result; req keeps flowing until the
//  input register is also occupied.
// ----------------------------------------------------------------------------
module arm_instruction_classify
   import aic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] instr_word, [32] flag_negative, [33] flag_zero,
   // [34] flag_carry, [35] flag_overflow, [39:36] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] format_code, [4] cond_passed, [7:5] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               in_valid_ff, in_valid_in;
   logic [INSTR_W-1:0] instr_ff;
   flags_type          flags_ff;
   logic               out_valid_ff, out_valid_in;
   result_type         result_ff;
   result_type         result_in;
   logic               out_load;
   logic               in_load;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   aic_format u_format (
      .instr_word  (instr_ff),
      .format_code (result_in.format_code)
   );

   aic_cond u_cond (
      .cond        (instr_ff[31:28]),
      .flags       (flags_ff),
      .cond_passed (result_in.cond_passed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         instr_ff          <= req_tdata[31:0];
         flags_ff.negative <= req_tdata[32];
         flags_ff.zero     <= req_tdata[33];
         flags_ff.carry    <= req_tdata[34];
         flags_ff.overflow <= req_tdata[35];
      end
      if (out_load && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff};

endmodule

>>> hw/rtl/aic_checker.sv
// ----------------------------------------------------------------------------
// aic_checker
// Port-level checks for the instruction classifier, bound to the top level.
// ----------------------------------------------------------------------------
module aic_checker
   import aic_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transfer changed");

   // every word falls into some class, and the pad bits stay zero
   a_no_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] != FMT_UNKNOWN && rsp_tdata[7:5] == 3'b000)
      else $error("unknown format or nonzero pad");

   // a draining output never blocks the input side
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp drains");

   // an accepted item leaves no empty output behind it
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready |=> ##1 rsp_tvalid)
      else $error("accepted item did not reach the output");

endmodule

bind arm_instruction_classify aic_checker u_aic_checker (.*);
